[rtl/core/edit_distance_engine_core_assert.svh]
// Assertion macros shared by the edit distance engine RTL.
// Depends on nothing; each use names its own clock and reset.
`ifndef EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edc assertion failed");

`endif

[rtl/core/edc_pkg.sv]
// Package for the edit distance engine: sizes, operation codes, sequencer
// states and the distance saturation function. Depends on nothing.
`default_nettype none

package edc_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SYM_W   = 8;
  localparam int DIST_W  = 7;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_SRC     = 2'd0;
  localparam logic [OP_W-1:0] OP_TGT     = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROW_RD,
    S_ROW_WR,
    S_CELL_RD,
    S_CELL_WR
  } state_t;

  // Clamp a cost value into the distance field.
  function automatic logic [DIST_W-1:0] sat_dist(input logic [LEN_W-1:0] v);
    logic [LEN_W+DIST_W-1:0] w;
    w = (LEN_W + DIST_W)'(v);
    if (w > (LEN_W + DIST_W)'((1 << DIST_W) - 1)) begin
      return {DIST_W{1'b1}};
    end
    return w[DIST_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/edc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module edc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/edit_distance_engine_core.sv]
// Top level of the edit distance engine: command port, sequencer and the
// table walk datapath. Depends on edc_pkg, edc_ram and the assertion header.
//
// Usage. A command beat is taken at a rising edge where start is high and
// busy is low; operation and symbol travel with it. Operation OP_SRC
// appends symbol to the source string, OP_TGT appends it to the target
// string; neither raises busy. A byte beyond MAX_LEN is dropped and
// remembered as an overflow. The unused operation code is taken and ignored.
// OP_COMPUTE raises busy while the Levenshtein distance is worked out over
// one stored cost row. The row is first initialised one entry a cycle in
// S_INIT. Each table cell then passes through S_CELL_RD, which issues the
// reads of the row memory and the source memory, and S_CELL_WR, which takes
// the registered data, compares and writes the cell back. Each row first passes
// through S_ROW_RD and S_ROW_WR to fetch its target byte. The result beat (done,
// distance, overflow) appears for exactly one cycle after the last cell, busy
// falls in that same cycle, and both strings and the overflow flag are cleared.
// The receiver cannot stall, so the result beat must be taken as it comes.
// A synchronous reset empties both strings, clears the flag and idles the walk.
`default_nettype none
`include "edit_distance_engine_core_assert.svh"

module edit_distance_engine_core
  import edc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [SYM_W-1:0]  symbol,
  output logic                   done,
  output logic [DIST_W-1:0]      distance,
  output logic                   overflow
);

  // Sequencer and control registers.
  state_t           state, state_next;
  logic [LEN_W-1:0] src_len, src_len_next;
  logic [LEN_W-1:0] tgt_len, tgt_len_next;
  logic             overflow_seen, overflow_seen_next;
  logic [LEN_W-1:0] row_idx, row_idx_next;
  logic [LEN_W-1:0] col_idx, col_idx_next;

  // Datapath registers of the table walk.
  logic [LEN_W-1:0] diag, diag_next;
  logic [LEN_W-1:0] left, left_next;
  logic [SYM_W-1:0] tgt_sym, tgt_sym_next;

  // Result strobe and result cost, both combinational.
  logic             finish;
  logic [LEN_W-1:0] result_cost;

  // Memory ports.
  logic              src_we, tgt_we, row_we;
  logic [ADDR_W-1:0] src_raddr, tgt_raddr;
  logic [SYM_W-1:0]  src_rdata, tgt_rdata;
  logic [LEN_W-1:0]  row_waddr, row_raddr;
  logic [LEN_W-1:0]  row_wdata, row_rdata;

  // Shared compare unit: minimum of three neighbours plus one, or the
  // diagonal where the two bytes match.
  logic [LEN_W-1:0] least;
  logic [LEN_W-1:0] cell_cost;
  logic             accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    least = diag;
    if (row_rdata < least) begin
      least = row_rdata;
    end
    if (left < least) begin
      least = left;
    end
    cell_cost = (src_rdata == tgt_sym) ? diag : least + LEN_W'(1);
  end

  edc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_len[ADDR_W-1:0]),
    .wdata (symbol),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  edc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_len[ADDR_W-1:0]),
    .wdata (symbol),
    .raddr (tgt_raddr),
    .rdata (tgt_rdata)
  );

  edc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN + 1)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // Next state, datapath updates and memory controls.
  always_comb begin
    state_next         = state;
    src_len_next       = src_len;
    tgt_len_next       = tgt_len;
    overflow_seen_next = overflow_seen;
    row_idx_next       = row_idx;
    col_idx_next       = col_idx;
    diag_next          = diag;
    left_next          = left;
    tgt_sym_next       = tgt_sym;
    finish             = 1'b0;
    result_cost        = cell_cost;
    src_we             = 1'b0;
    tgt_we             = 1'b0;
    row_we             = 1'b0;
    row_waddr          = col_idx;
    row_wdata          = col_idx;
    row_raddr          = col_idx;
    src_raddr          = ADDR_W'(col_idx - LEN_W'(1));
    tgt_raddr          = ADDR_W'(row_idx - LEN_W'(1));

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_SRC: begin
              if (src_len < LEN_W'(MAX_LEN)) begin
                src_we       = 1'b1;
                src_len_next = src_len + LEN_W'(1);
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            OP_TGT: begin
              if (tgt_len < LEN_W'(MAX_LEN)) begin
                tgt_we       = 1'b1;
                tgt_len_next = tgt_len + LEN_W'(1);
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            OP_COMPUTE: begin
              col_idx_next = '0;
              state_next   = S_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      // First row of the table: entry j holds j.
      S_INIT: begin
        row_we = 1'b1;
        if (col_idx == src_len) begin
          if (tgt_len == '0) begin
            finish      = 1'b1;
            result_cost = src_len;
            state_next  = S_IDLE;
          end else begin
            row_idx_next = LEN_W'(1);
            state_next   = S_ROW_RD;
          end
        end else begin
          col_idx_next = col_idx + LEN_W'(1);
        end
      end

      // Fetch the target byte of this row.
      S_ROW_RD: begin
        state_next = S_ROW_WR;
      end

      // Column zero of row i holds i; the old value i - 1 is the diagonal.
      S_ROW_WR: begin
        tgt_sym_next = tgt_rdata;
        diag_next    = row_idx - LEN_W'(1);
        left_next    = row_idx;
        row_we       = 1'b1;
        row_waddr    = '0;
        row_wdata    = row_idx;
        col_idx_next = LEN_W'(1);
        if (src_len == '0) begin
          if (row_idx == tgt_len) begin
            finish      = 1'b1;
            result_cost = row_idx;
            state_next  = S_IDLE;
          end else begin
            row_idx_next = row_idx + LEN_W'(1);
            state_next   = S_ROW_RD;
          end
        end else begin
          state_next = S_CELL_RD;
        end
      end

      // Read the cell above and the source byte of this column.
      S_CELL_RD: begin
        state_next = S_CELL_WR;
      end

      S_CELL_WR: begin
        row_we    = 1'b1;
        row_wdata = cell_cost;
        diag_next = row_rdata;
        left_next = cell_cost;
        if (col_idx == src_len) begin
          if (row_idx == tgt_len) begin
            finish      = 1'b1;
            result_cost = cell_cost;
            state_next  = S_IDLE;
          end else begin
            row_idx_next = row_idx + LEN_W'(1);
            state_next   = S_ROW_RD;
          end
        end else begin
          col_idx_next = col_idx + LEN_W'(1);
          state_next   = S_CELL_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A finished request empties both strings and clears the flag.
    if (finish) begin
      src_len_next       = '0;
      tgt_len_next       = '0;
      overflow_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      src_len       <= '0;
      tgt_len       <= '0;
      overflow_seen <= 1'b0;
      row_idx       <= '0;
      col_idx       <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      src_len       <= src_len_next;
      tgt_len       <= tgt_len_next;
      overflow_seen <= overflow_seen_next;
      row_idx       <= row_idx_next;
      col_idx       <= col_idx_next;
      done          <= finish;
    end
  end

  always_ff @(posedge clk) begin
    diag    <= diag_next;
    left    <= left_next;
    tgt_sym <= tgt_sym_next;
    if (finish) begin
      distance <= sat_dist(result_cost);
      overflow <= overflow_seen;
    end
  end

  // The result beat only ever appears once the sequencer is back at rest.
  `EDC_ASSERT_SAME(a_done_idle, clk, rst, done, state == S_IDLE)
  // A compute command always starts a walk.
  `EDC_ASSERT_NEXT(a_compute_busy, clk, rst,
    accept && (operation == OP_COMPUTE), busy)
  // Column index stays within the source string while cells are written.
  `EDC_ASSERT_SAME(a_col_range, clk, rst, state == S_CELL_WR,
    (col_idx >= LEN_W'(1)) && (col_idx <= src_len))
  // Row index stays within the target string.
  `EDC_ASSERT_SAME(a_row_range, clk, rst, state == S_ROW_RD,
    (row_idx >= LEN_W'(1)) && (row_idx <= tgt_len))

endmodule

`default_nettype wire
